### rtl/irrigation_pump_sequencer_core_assert.svh
// Assertion macros used by the irrigation pump sequencer RTL.
`ifndef IRRIGATION_PUMP_SEQUENCER_CORE_ASSERT_SVH
`define IRRIGATION_PUMP_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define IPS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define IPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ips_pkg.sv
// Shared types, codes and helper functions of the irrigation pump sequencer.
package ips_pkg;

    // Field widths.
    localparam int REQ_W      = 2;
    localparam int ZONE_W     = 2;
    localparam int PHASE_W    = 4;
    localparam int DUTY_W     = 7;
    localparam int STAGE_W    = 4;
    localparam int ERR_W      = 2;
    localparam int TIMER_W    = 20;
    localparam int TICKS_W    = 16;
    localparam int BYTE_W     = 8;
    localparam int GAP_W      = 16;
    localparam int TABLE_W    = 64;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_IDX_LSB = 3;

    // Ramp numerator holds duty times a tick count.
    localparam int NUM_W   = DUTY_W + TICKS_W;
    localparam int RECIP_W = NUM_W + 2;

    // Scale factors of the duration registers.
    localparam logic [9:0] MS_PER_SECOND = 10'd1000;
    localparam logic [3:0] MS_PER_GAP_UNIT = 4'd10;
    localparam logic [BYTE_W-1:0] DUTY_MAX = 8'd100;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ABORT = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RELAY   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DUTY    = 2'd2;
    localparam logic [ERR_W-1:0] ERR_FAULT   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_TABLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECS_TABLE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP         = 2'd3;

    // Phase codes as seen on the result channel.
    localparam logic [PHASE_W-1:0] PHC_IDLE      = 4'd0;
    localparam logic [PHASE_W-1:0] PHC_VALVE     = 4'd1;
    localparam logic [PHASE_W-1:0] PHC_MAIN      = 4'd2;
    localparam logic [PHASE_W-1:0] PHC_STAGE     = 4'd3;
    localparam logic [PHASE_W-1:0] PHC_RAMP      = 4'd4;
    localparam logic [PHASE_W-1:0] PHC_MAIN_OFF  = 4'd5;
    localparam logic [PHASE_W-1:0] PHC_VALVE_OFF = 4'd6;
    localparam logic [PHASE_W-1:0] PHC_GAP       = 4'd7;
    localparam logic [PHASE_W-1:0] PHC_DONE      = 4'd8;
    localparam logic [PHASE_W-1:0] PHC_ERROR     = 4'd9;

    // Sequencer phases, one-hot.
    typedef enum logic [9:0] {
        PH_IDLE      = 10'b00_0000_0001,
        PH_VALVE     = 10'b00_0000_0010,
        PH_MAIN      = 10'b00_0000_0100,
        PH_STAGE     = 10'b00_0000_1000,
        PH_RAMP      = 10'b00_0001_0000,
        PH_MAIN_OFF  = 10'b00_0010_0000,
        PH_VALVE_OFF = 10'b00_0100_0000,
        PH_GAP       = 10'b00_1000_0000,
        PH_DONE      = 10'b01_0000_0000,
        PH_ERROR     = 10'b10_0000_0000
    } phase_t;

    // One accepted request.
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ZONE_W-1:0] zone;
        logic              abort_fault;
        logic              relay_refused;
    } item_t;

    // Configuration register contents.
    typedef struct packed {
        logic [STAGE_W-1:0] stage_count;
        logic [TABLE_W-1:0] duty_table;
        logic [TABLE_W-1:0] secs_table;
        logic [GAP_W-1:0]   gap_tens_ms;
    } cfg_t;

    // One result.
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               valve_on;
        logic [ZONE_W-1:0]  valve_zone;
        logic               main_on;
        logic [DUTY_W-1:0]  pump_duty;
        logic [STAGE_W-1:0] stage_index;
        logic               busy_res;
        logic [ERR_W-1:0]   error_code;
        logic [DUTY_W-1:0]  peak_duty;
    } res_t;

    // Map a one-hot phase onto its external code.
    function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
        logic [PHASE_W-1:0] code;
        unique case (ph)
            PH_IDLE:      code = PHC_IDLE;
            PH_VALVE:     code = PHC_VALVE;
            PH_MAIN:      code = PHC_MAIN;
            PH_STAGE:     code = PHC_STAGE;
            PH_RAMP:      code = PHC_RAMP;
            PH_MAIN_OFF:  code = PHC_MAIN_OFF;
            PH_VALVE_OFF: code = PHC_VALVE_OFF;
            PH_GAP:       code = PHC_GAP;
            PH_DONE:      code = PHC_DONE;
            PH_ERROR:     code = PHC_ERROR;
            default:      code = PHC_IDLE;
        endcase
        return code;
    endfunction

endpackage

### rtl/ips_if.sv
// Request and result channel interfaces of the irrigation pump sequencer.
interface ips_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [1:0] zone;
    logic       abort_fault;
    logic       relay_refused;

    modport source (output valid, output req_type, output zone, output abort_fault,
                    output relay_refused, input ready);
    modport sink (input valid, input req_type, input zone, input abort_fault,
                  input relay_refused, output ready);
endinterface

interface ips_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] phase;
    logic       valve_on;
    logic [1:0] valve_zone;
    logic       main_on;
    logic [6:0] pump_duty;
    logic [3:0] stage_index;
    logic       busy_res;
    logic [1:0] error_code;
    logic [6:0] peak_duty;

    modport source (output valid, output phase, output valve_on, output valve_zone,
                    output main_on, output pump_duty, output stage_index,
                    output busy_res, output error_code, output peak_duty, input ready);
    modport sink (input valid, input phase, input valve_on, input valve_zone,
                  input main_on, input pump_duty, input stage_index,
                  input busy_res, input error_code, input peak_duty, output ready);
endinterface

### rtl/ips_cfg.sv
// APB-style configuration register file of the irrigation pump sequencer.
module ips_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ips_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ips_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ips_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output ips_pkg::cfg_t                  cfg
);
    import ips_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[CFG_IDX_LSB +: CFG_IDX_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_STAGE_COUNT: cfg_next.stage_count = pwdata[STAGE_W-1:0];
                REG_DUTY_TABLE:  cfg_next.duty_table  = pwdata[TABLE_W-1:0];
                REG_SECS_TABLE:  cfg_next.secs_table  = pwdata[TABLE_W-1:0];
                REG_GAP:         cfg_next.gap_tens_ms = pwdata[GAP_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back mux.
    always_comb
    begin
        unique case (reg_idx)
            REG_STAGE_COUNT: prdata = {{(CFG_DATA_W-STAGE_W){1'b0}}, cfg_reg.stage_count};
            REG_DUTY_TABLE:  prdata = cfg_reg.duty_table;
            REG_SECS_TABLE:  prdata = cfg_reg.secs_table;
            REG_GAP:         prdata = {{(CFG_DATA_W-GAP_W){1'b0}}, cfg_reg.gap_tens_ms};
            default:         prdata = '0;
        endcase
    end

endmodule

### rtl/ips_seq.sv
// Phase sequencer: state registers and the next-state update for one request.
module ips_seq #(
    parameter int MAX_STAGES         = 8,
    parameter int VALVE_SETTLE_TICKS = 200,
    parameter int MAIN_SETTLE_TICKS  = 100,
    parameter int RAMP_TICKS         = 500,
    parameter int MAIN_RELAX_TICKS   = 500,
    parameter int VALVE_CLOSE_TICKS  = 50
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  ips_pkg::item_t item,
    input  ips_pkg::cfg_t  cfg,
    output ips_pkg::res_t  res
);
    import ips_pkg::*;

    // Reciprocal of the ramp length, exact for every numerator below 2**NUM_W.
    localparam int RampLog   = $clog2(RAMP_TICKS);
    localparam int RampShift = NUM_W + RampLog;
    localparam int ProdW     = NUM_W + RECIP_W;
    localparam logic [63:0] RampRecip =
        ((64'd1 << RampShift) + 64'(RAMP_TICKS) - 64'd1) / 64'(RAMP_TICKS);
    localparam logic [RECIP_W-1:0] RecipC = RampRecip[RECIP_W-1:0];
    localparam logic [TICKS_W-1:0] RampM1 = TICKS_W'(RAMP_TICKS - 1);

    localparam logic [STAGE_W-1:0] MaxStages   = STAGE_W'(MAX_STAGES);
    localparam logic [TIMER_W-1:0] ValveSettle = TIMER_W'(VALVE_SETTLE_TICKS);
    localparam logic [TIMER_W-1:0] MainSettle  = TIMER_W'(MAIN_SETTLE_TICKS);
    localparam logic [TIMER_W:0]   RampLen     = (TIMER_W+1)'(RAMP_TICKS);
    localparam logic [TIMER_W-1:0] MainRelax   = TIMER_W'(MAIN_RELAX_TICKS);
    localparam logic [TIMER_W-1:0] ValveClose  = TIMER_W'(VALVE_CLOSE_TICKS);
    localparam logic [TIMER_W-1:0] TimerMax    = '1;

    // State registers; they also form the result register.
    phase_t             phase_reg, phase_next;
    logic [ZONE_W-1:0]  zone_reg, zone_next;
    logic [STAGE_W-1:0] stage_reg, stage_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [DUTY_W-1:0]  duty_reg, duty_next;
    logic [DUTY_W-1:0]  ramp_start_reg, ramp_start_next;
    logic [DUTY_W-1:0]  peak_reg, peak_next;
    logic               valve_reg, valve_next;
    logic               main_reg, main_next;
    logic [ERR_W-1:0]   error_reg, error_next;
    logic [NUM_W-1:0]   num_reg, num_next;

    logic [DUTY_W-1:0]  duty_base;
    logic               ramp_upd;
    logic               entered;
    logic               t0;
    logic [STAGE_W-1:0] limit;
    logic [BYTE_W-1:0]  stage_duty;
    logic [BYTE_W-1:0]  stage_secs;
    logic [TIMER_W-1:0] stage_len;
    logic [TIMER_W-1:0] gap_len;
    logic [DUTY_W-1:0]  ramp_s;
    logic [ProdW-1:0]   ramp_prod;
    logic [DUTY_W-1:0]  ramp_q;

    // Per-stage lookups and scaled durations.
    assign t0         = (timer_reg == '0);
    assign limit      = (cfg.stage_count > MaxStages) ? MaxStages : cfg.stage_count;
    assign stage_duty = cfg.duty_table[stage_reg[2:0]*BYTE_W +: BYTE_W];
    assign stage_secs = cfg.secs_table[stage_reg[2:0]*BYTE_W +: BYTE_W];
    assign stage_len  = TIMER_W'(stage_secs * MS_PER_SECOND);
    assign gap_len    = TIMER_W'(cfg.gap_tens_ms * MS_PER_GAP_UNIT);

    // Ramp duty: the numerator register tracks start duty times remaining ticks.
    assign ramp_s    = t0 ? duty_reg : ramp_start_reg;
    assign ramp_prod = ProdW'(num_reg) * ProdW'(RecipC);
    assign ramp_q    = ramp_prod[RampShift +: DUTY_W];

    // Next-state logic for one request.
    always_comb
    begin
        phase_next      = phase_reg;
        zone_next       = zone_reg;
        stage_next      = stage_reg;
        timer_next      = timer_reg;
        duty_base       = duty_reg;
        ramp_start_next = ramp_start_reg;
        peak_next       = peak_reg;
        valve_next      = valve_reg;
        main_next       = main_reg;
        error_next      = error_reg;
        ramp_upd        = 1'b0;
        entered         = 1'b0;

        unique case (item.req_type)
            REQ_TICK:
            begin
                unique case (phase_reg)
                    PH_VALVE:
                    begin
                        if (t0 && item.relay_refused)
                        begin
                            duty_base  = '0;
                            main_next  = 1'b0;
                            error_next = ERR_RELAY;
                            phase_next = PH_ERROR;
                            entered    = 1'b1;
                        end
                        else
                        begin
                            if (t0)
                            begin
                                valve_next = 1'b1;
                            end
                            if (timer_reg >= ValveSettle)
                            begin
                                phase_next = PH_MAIN;
                                entered    = 1'b1;
                            end
                        end
                    end
                    PH_MAIN:
                    begin
                        if (t0 && item.relay_refused)
                        begin
                            duty_base  = '0;
                            main_next  = 1'b0;
                            error_next = ERR_RELAY;
                            phase_next = PH_ERROR;
                            entered    = 1'b1;
                        end
                        else
                        begin
                            if (t0)
                            begin
                                main_next = 1'b1;
                            end
                            if (timer_reg >= MainSettle)
                            begin
                                stage_next = '0;
                                phase_next = PH_STAGE;
                                entered    = 1'b1;
                            end
                        end
                    end
                    PH_STAGE:
                    begin
                        if (stage_reg >= limit)
                        begin
                            phase_next = PH_RAMP;
                            entered    = 1'b1;
                        end
                        else if (t0 && (stage_duty > DUTY_MAX))
                        begin
                            duty_base  = '0;
                            main_next  = 1'b0;
                            error_next = ERR_DUTY;
                            phase_next = PH_ERROR;
                            entered    = 1'b1;
                        end
                        else
                        begin
                            if (t0)
                            begin
                                duty_base = stage_duty[DUTY_W-1:0];
                                if (stage_duty[DUTY_W-1:0] > peak_reg)
                                begin
                                    peak_next = stage_duty[DUTY_W-1:0];
                                end
                            end
                            if (timer_reg >= stage_len)
                            begin
                                stage_next = stage_reg + 1'b1;
                                phase_next = PH_STAGE;
                                entered    = 1'b1;
                            end
                        end
                    end
                    PH_RAMP:
                    begin
                        if (t0)
                        begin
                            ramp_start_next = duty_reg;
                        end
                        if (({1'b0, timer_reg} + 1'b1) >= RampLen)
                        begin
                            duty_base  = '0;
                            phase_next = PH_MAIN_OFF;
                            entered    = 1'b1;
                        end
                        else
                        begin
                            ramp_upd = 1'b1;
                        end
                    end
                    PH_MAIN_OFF:
                    begin
                        if (t0)
                        begin
                            main_next = 1'b0;
                        end
                        if (timer_reg >= MainRelax)
                        begin
                            phase_next = PH_VALVE_OFF;
                            entered    = 1'b1;
                        end
                    end
                    PH_VALVE_OFF:
                    begin
                        if (t0)
                        begin
                            valve_next = 1'b0;
                        end
                        if (timer_reg >= ValveClose)
                        begin
                            phase_next = PH_GAP;
                            entered    = 1'b1;
                        end
                    end
                    PH_GAP:
                    begin
                        if (timer_reg >= gap_len)
                        begin
                            phase_next = PH_DONE;
                            entered    = 1'b1;
                        end
                    end
                    PH_IDLE, PH_DONE, PH_ERROR:
                    begin
                        phase_next = phase_reg;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase

                // Phase timer restarts on entry, else counts up and saturates.
                if (entered)
                begin
                    timer_next = '0;
                end
                else if (timer_reg != TimerMax)
                begin
                    timer_next = timer_reg + 1'b1;
                end
            end
            REQ_START:
            begin
                zone_next  = item.zone;
                stage_next = '0;
                peak_next  = '0;
                error_next = ERR_NONE;
                phase_next = PH_VALVE;
                timer_next = '0;
            end
            REQ_ABORT:
            begin
                duty_base  = '0;
                main_next  = 1'b0;
                error_next = item.abort_fault ? ERR_FAULT : ERR_NONE;
                phase_next = item.abort_fault ? PH_ERROR : PH_DONE;
                timer_next = '0;
            end
            REQ_NONE:
            begin
                phase_next = phase_reg;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Duty selection and the ramp numerator for the following tick.
    always_comb
    begin
        duty_next = ramp_upd ? ramp_q : duty_base;
        if (phase_reg == PH_RAMP)
        begin
            if (item.req_type == REQ_TICK)
            begin
                num_next = num_reg - NUM_W'(ramp_s);
            end
            else
            begin
                num_next = num_reg;
            end
        end
        else
        begin
            num_next = NUM_W'(duty_base * RampM1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            zone_reg       <= '0;
            stage_reg      <= '0;
            timer_reg      <= '0;
            duty_reg       <= '0;
            ramp_start_reg <= '0;
            peak_reg       <= '0;
            valve_reg      <= 1'b0;
            main_reg       <= 1'b0;
            error_reg      <= ERR_NONE;
            num_reg        <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            zone_reg       <= zone_next;
            stage_reg      <= stage_next;
            timer_reg      <= timer_next;
            duty_reg       <= duty_next;
            ramp_start_reg <= ramp_start_next;
            peak_reg       <= peak_next;
            valve_reg      <= valve_next;
            main_reg       <= main_next;
            error_reg      <= error_next;
            num_reg        <= num_next;
        end
    end

    // Result fields straight from the state registers.
    always_comb
    begin
        res.phase       = phase_code(phase_reg);
        res.valve_on    = valve_reg;
        res.valve_zone  = zone_reg;
        res.main_on     = main_reg;
        res.pump_duty   = duty_reg;
        res.stage_index = stage_reg;
        res.busy_res    = !((phase_reg == PH_IDLE) || (phase_reg == PH_DONE)
                            || (phase_reg == PH_ERROR));
        res.error_code  = error_reg;
        res.peak_duty   = peak_reg;
    end

endmodule

### rtl/irrigation_pump_sequencer_core.sv
// Top level of the irrigation pump sequencer: channel staging, registers, sequencer.
//
//   Channel   Role     Handshake       Payload
//   req       sink     valid/ready     req_type, zone, abort_fault, relay_refused
//   res       source   valid/ready     phase, relays, duty, stage, busy, error, peak
//   APB       slave    psel/penable    4 registers, 64-bit data, byte address 8*i
//
// A request transaction lands in the input register and is processed from there into
// the sequencer state registers, which form the result register; one request per cycle
// is sustained while no result stalls. The rate is set by the state update, whose
// longest path is the ramp reciprocal multiply. rst_n clears all control and state at
// once; no clearing pass. A stalled result holds its register and the input register,
// and req.ready drops only while both are full.
`include "irrigation_pump_sequencer_core_assert.svh"

module irrigation_pump_sequencer_core #(
    parameter int MAX_STAGES         = 8,
    parameter int VALVE_SETTLE_TICKS = 200,
    parameter int MAIN_SETTLE_TICKS  = 100,
    parameter int RAMP_TICKS         = 500,
    parameter int MAIN_RELAX_TICKS   = 500,
    parameter int VALVE_CLOSE_TICKS  = 50
) (
    input  logic                           clk,
    input  logic                           rst_n,
    ips_req_if.sink                        req,
    ips_res_if.source                      res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ips_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ips_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ips_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import ips_pkg::*;

    cfg_t  cfg;
    res_t  seq_res;
    item_t in_item_reg, in_item_next;
    logic  in_valid_reg, in_valid_next;
    logic  out_valid_reg, out_valid_next;
    logic  advance;
    logic  step;

    // Configuration registers.
    ips_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Pipeline control: the work stage moves when the result register is free.
    assign advance   = !out_valid_reg || res.ready;
    assign step      = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (req.ready)
        begin
            in_valid_next          = req.valid;
            in_item_next.req_type      = req.req_type;
            in_item_next.zone          = req.zone;
            in_item_next.abort_fault   = req.abort_fault;
            in_item_next.relay_refused = req.relay_refused;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
    end

    // Sequencer; its state registers double as the result register.
    ips_seq #(
        .MAX_STAGES         (MAX_STAGES),
        .VALVE_SETTLE_TICKS (VALVE_SETTLE_TICKS),
        .MAIN_SETTLE_TICKS  (MAIN_SETTLE_TICKS),
        .RAMP_TICKS         (RAMP_TICKS),
        .MAIN_RELAX_TICKS   (MAIN_RELAX_TICKS),
        .VALVE_CLOSE_TICKS  (VALVE_CLOSE_TICKS)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (seq_res)
    );

    // Result channel drive.
    assign res.valid       = out_valid_reg;
    assign res.phase       = seq_res.phase;
    assign res.valve_on    = seq_res.valve_on;
    assign res.valve_zone  = seq_res.valve_zone;
    assign res.main_on     = seq_res.main_on;
    assign res.pump_duty   = seq_res.pump_duty;
    assign res.stage_index = seq_res.stage_index;
    assign res.busy_res    = seq_res.busy_res;
    assign res.error_code  = seq_res.error_code;
    assign res.peak_duty   = seq_res.peak_duty;

    // Design checks.
    `IPS_ASSERT_NEXT(a_step_gives_result, step, out_valid_reg, "processed request left no result")
    `IPS_ASSERT_IMPLIES(a_duty_range, out_valid_reg, seq_res.pump_duty <= 7'd100, "duty above 100")
    `IPS_ASSERT_IMPLIES(a_main_needs_valve, seq_res.main_on, seq_res.valve_on, "pump on, valve shut")
    `IPS_ASSERT_IMPLIES(a_error_phase, seq_res.error_code != ERR_NONE, seq_res.phase == PHC_ERROR, "error code outside error phase")

endmodule
